// ===== rtl/core/sgrcp_pkg.sv =====
// Package for the SGR color parameter parser: widths, codes, types and the palette.
// Used by the interfaces and by every module of the core; depends on nothing.
package sgrcp_pkg;

  localparam int ParamW = 16;
  localparam int ColorW = 24;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  localparam logic [ColorW-1:0] FgDefaultReset = 24'hE5E5E5;
  localparam logic [ColorW-1:0] BgDefaultReset = 24'h000000;

  localparam logic RegFgDefault = 1'b0;
  localparam logic RegBgDefault = 1'b1;

  localparam logic signed [ParamW-1:0] CodeFgLo   = 16'sd30;
  localparam logic signed [ParamW-1:0] CodeFgHi   = 16'sd37;
  localparam logic signed [ParamW-1:0] CodeFgExt  = 16'sd38;
  localparam logic signed [ParamW-1:0] CodeFgDef  = 16'sd39;
  localparam logic signed [ParamW-1:0] CodeFgBrLo = 16'sd90;
  localparam logic signed [ParamW-1:0] CodeFgBrHi = 16'sd97;
  localparam logic signed [ParamW-1:0] CodeBgLo   = 16'sd40;
  localparam logic signed [ParamW-1:0] CodeBgHi   = 16'sd47;
  localparam logic signed [ParamW-1:0] CodeBgExt  = 16'sd48;
  localparam logic signed [ParamW-1:0] CodeBgDef  = 16'sd49;
  localparam logic signed [ParamW-1:0] CodeBgBrLo = 16'sd100;
  localparam logic signed [ParamW-1:0] CodeBgBrHi = 16'sd107;
  localparam logic signed [ParamW-1:0] ModeIndex  = 16'sd5;
  localparam logic signed [ParamW-1:0] ModeRgb    = 16'sd2;
  localparam logic [7:0]               BrightBase = 8'd8;

  typedef enum logic [2:0] {
    PH_CODE  = 3'd0,
    PH_MODE  = 3'd1,
    PH_INDEX = 3'd2,
    PH_RED   = 3'd3,
    PH_GREEN = 3'd4,
    PH_BLUE  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CC_NONE,
    CC_FG_PAL,
    CC_BG_PAL,
    CC_FG_DEF,
    CC_BG_DEF,
    CC_FG_EXT,
    CC_BG_EXT
  } code_e;

  typedef struct packed {
    logic                    valid;
    logic signed [ParamW-1:0] param;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic [ColorW-1:0] fg_default;
    logic [ColorW-1:0] bg_default;
    logic              fg_load;
    logic              bg_load;
  } cfg_t;

  typedef logic [255:0][ColorW-1:0] palette_t;

  localparam logic [ColorW-1:0] Base16 [16] = '{
    24'h000000, 24'h0000CD, 24'h00CD00, 24'h00CDCD,
    24'hEE0000, 24'hCD00CD, 24'hCDCD00, 24'hE5E5E5,
    24'h7F7F7F, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF5C5C, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  localparam logic [7:0] GreyRamp [24] = '{
    8'h00, 8'h0B, 8'h16, 8'h21, 8'h2C, 8'h37, 8'h42, 8'h4D,
    8'h58, 8'h63, 8'h6F, 8'h7A, 8'h85, 8'h90, 8'h9B, 8'hA6,
    8'hB1, 8'hBC, 8'hC7, 8'hD3, 8'hDE, 8'hE9, 8'hF4, 8'hFF
  };

  function automatic palette_t build_palette();
    palette_t p;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      p[i] = Base16[i];
    end
    for (int r = 0; r < 6; r++) begin
      for (int g = 0; g < 6; g++) begin
        for (int b = 0; b < 6; b++) begin
          p[16 + 36 * r + 6 * g + b] = {8'(51 * b), 8'(51 * g), 8'(51 * r)};
        end
      end
    end
    for (int i = 0; i < 24; i++) begin
      p[232 + i] = {GreyRamp[i], GreyRamp[i], GreyRamp[i]};
    end
    return p;
  endfunction

  localparam palette_t Palette = build_palette();

endpackage

// ===== rtl/core/sgrcp_ifs.sv =====
// Valid/ready channel interfaces for parameter items and color results.
// Depends on sgrcp_pkg for the field widths.
interface sgrcp_param_if;
  import sgrcp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ParamW-1:0] param;
  logic                     last;
  modport source (output valid, output param, output last, input ready);
  modport sink (input valid, input param, input last, output ready);
endinterface

interface sgrcp_color_if;
  import sgrcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] fg_color;
  logic [ColorW-1:0] bg_color;
  modport source (output valid, output fg_color, output bg_color, input ready);
  modport sink (input valid, input fg_color, input bg_color, output ready);
endinterface

// ===== rtl/core/sgrcp_cfg_regs.sv =====
// APB register file holding the default foreground and background colors.
// Depends on sgrcp_pkg for widths, register indexes and the cfg_t struct.
module sgrcp_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sgrcp_pkg::AddrW-1:0] paddr,
  input  logic [sgrcp_pkg::DataW-1:0] pwdata,
  output logic [sgrcp_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output sgrcp_pkg::cfg_t            cfg_o
);
  import sgrcp_pkg::*;

  logic              wr_en;
  logic              reg_sel;
  logic [ColorW-1:0] fg_default_q;
  logic [ColorW-1:0] bg_default_q;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_default_q <= FgDefaultReset;
      bg_default_q <= BgDefaultReset;
    end else if (wr_en) begin
      if (reg_sel == RegFgDefault) begin
        fg_default_q <= pwdata[ColorW-1:0];
      end else begin
        bg_default_q <= pwdata[ColorW-1:0];
      end
    end
  end

  assign prdata = (reg_sel == RegFgDefault) ? DataW'(fg_default_q) : DataW'(bg_default_q);

  assign cfg_o.fg_default = (wr_en && reg_sel == RegFgDefault) ? pwdata[ColorW-1:0]
                                                               : fg_default_q;
  assign cfg_o.bg_default = (wr_en && reg_sel == RegBgDefault) ? pwdata[ColorW-1:0]
                                                               : bg_default_q;
  assign cfg_o.fg_load    = wr_en && (reg_sel == RegFgDefault);
  assign cfg_o.bg_load    = wr_en && (reg_sel == RegBgDefault);

endmodule

// ===== rtl/core/sgrcp_in_stage.sv =====
// Input register for parameter transactions; holds one item until the engine takes it.
// Depends on sgrcp_pkg and the sgrcp_param_if interface.
module sgrcp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  sgrcp_param_if.sink         in_i,
  input  logic                take_i,
  output sgrcp_pkg::item_t    item_o
);
  import sgrcp_pkg::*;

  logic                     valid_q;
  logic signed [ParamW-1:0] param_q;
  logic                     last_q;

  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      param_q <= in_i.param;
      last_q  <= in_i.last;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.param = param_q;
  assign item_o.last  = last_q;

endmodule

// ===== rtl/core/sgrcp_engine.sv =====
// Decodes one registered parameter per cycle unless stalled, updates the color state and
// loads the result register at the end of a sequence. Depends on sgrcp_pkg.
module sgrcp_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgrcp_pkg::item_t item_i,
  input  sgrcp_pkg::cfg_t  cfg_i,
  output logic             take_o,
  sgrcp_color_if.source    out_o
);
  import sgrcp_pkg::*;

  phase_e            phase_q, phase_d;
  logic              tbg_q, tbg_d;
  logic [7:0]        red_q, red_d;
  logic [7:0]        green_q, green_d;
  logic [ColorW-1:0] fg_q, fg_d;
  logic [ColorW-1:0] bg_q, bg_d;
  logic              out_vld_q;
  logic [ColorW-1:0] out_fg_q, out_bg_q;
  logic [ColorW-1:0] res_fg, res_bg;

  logic signed [ParamW-1:0] p;
  logic [7:0]        sub;
  code_e             code;
  logic [7:0]        code_idx;
  logic [7:0]        pal_idx;
  logic [ColorW-1:0] pal_color;
  logic              set_en;
  logic [ColorW-1:0] set_color;

  assign p      = item_i.param;
  assign take_o = item_i.valid && (!item_i.last || !out_vld_q || out_o.ready);
  assign sub    = (p[ParamW-1:8] == '0) ? p[7:0] : 8'd0;

  always_comb begin
    code     = CC_NONE;
    code_idx = 8'd0;
    if (p >= CodeFgLo && p <= CodeFgHi) begin
      code     = CC_FG_PAL;
      code_idx = 8'(p - CodeFgLo);
    end else if (p >= CodeFgBrLo && p <= CodeFgBrHi) begin
      code     = CC_FG_PAL;
      code_idx = 8'(p - CodeFgBrLo) + BrightBase;
    end else if (p >= CodeBgLo && p <= CodeBgHi) begin
      code     = CC_BG_PAL;
      code_idx = 8'(p - CodeBgLo);
    end else if (p >= CodeBgBrLo && p <= CodeBgBrHi) begin
      code     = CC_BG_PAL;
      code_idx = 8'(p - CodeBgBrLo) + BrightBase;
    end else if (p == CodeFgDef) begin
      code = CC_FG_DEF;
    end else if (p == CodeBgDef) begin
      code = CC_BG_DEF;
    end else if (p == CodeFgExt) begin
      code = CC_FG_EXT;
    end else if (p == CodeBgExt) begin
      code = CC_BG_EXT;
    end
  end

  assign pal_idx   = (phase_q == PH_INDEX) ? sub : code_idx;
  assign pal_color = Palette[pal_idx];

  always_comb begin
    phase_d   = PH_CODE;
    tbg_d     = tbg_q;
    red_d     = red_q;
    green_d   = green_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    set_en    = 1'b0;
    set_color = pal_color;
    case (phase_q)
      PH_MODE: begin
        if (p == ModeIndex) begin
          phase_d = PH_INDEX;
        end else if (p == ModeRgb) begin
          phase_d = PH_RED;
        end
      end
      PH_INDEX: begin
        set_en = 1'b1;
      end
      PH_RED: begin
        red_d   = sub;
        phase_d = PH_GREEN;
      end
      PH_GREEN: begin
        green_d = sub;
        phase_d = PH_BLUE;
      end
      PH_BLUE: begin
        set_en    = 1'b1;
        set_color = {sub, green_q, red_q};
      end
      default: begin
        case (code)
          CC_FG_PAL: fg_d = pal_color;
          CC_BG_PAL: bg_d = pal_color;
          CC_FG_DEF: fg_d = cfg_i.fg_default;
          CC_BG_DEF: bg_d = cfg_i.bg_default;
          CC_FG_EXT: begin
            tbg_d   = 1'b0;
            phase_d = PH_MODE;
          end
          CC_BG_EXT: begin
            tbg_d   = 1'b1;
            phase_d = PH_MODE;
          end
          default: ;
        endcase
      end
    endcase

    if (item_i.last) begin
      case (phase_d)
        PH_INDEX: begin
          set_en    = 1'b1;
          set_color = Palette[0];
        end
        PH_RED: begin
          set_en    = 1'b1;
          set_color = '0;
        end
        PH_GREEN: begin
          set_en    = 1'b1;
          set_color = {16'd0, red_d};
        end
        PH_BLUE: begin
          set_en    = 1'b1;
          set_color = {8'd0, green_d, red_d};
        end
        default: ;
      endcase
    end

    if (set_en) begin
      if (tbg_d) begin
        bg_d = set_color;
      end else begin
        fg_d = set_color;
      end
    end

    res_fg = fg_d;
    res_bg = bg_d;

    if (item_i.last) begin
      phase_d = PH_CODE;
      tbg_d   = 1'b0;
      red_d   = 8'd0;
      green_d = 8'd0;
      fg_d    = cfg_i.fg_default;
      bg_d    = cfg_i.bg_default;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      tbg_q   <= 1'b0;
      red_q   <= 8'd0;
      green_q <= 8'd0;
      fg_q    <= FgDefaultReset;
      bg_q    <= BgDefaultReset;
    end else begin
      if (take_o) begin
        phase_q <= phase_d;
        tbg_q   <= tbg_d;
        red_q   <= red_d;
        green_q <= green_d;
      end
      if (cfg_i.fg_load) begin
        fg_q <= cfg_i.fg_default;
      end else if (take_o) begin
        fg_q <= fg_d;
      end
      if (cfg_i.bg_load) begin
        bg_q <= cfg_i.bg_default;
      end else if (take_o) begin
        bg_q <= bg_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take_o && item_i.last) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && item_i.last) begin
      out_fg_q <= res_fg;
      out_bg_q <= res_bg;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.fg_color = out_fg_q;
  assign out_o.bg_color = out_bg_q;

  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last |=> out_vld_q)
    else $error("Result register not loaded after the final parameter.");

  a_last_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last |=> phase_q == PH_CODE && !tbg_q && red_q == 8'd0)
    else $error("Sequence state not cleared after the final parameter.");

  a_idle_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> $stable(phase_q) && $stable(red_q) && $stable(green_q))
    else $error("Sequence state changed without a parameter being taken.");

  a_no_take_on_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready && item_i.last |-> !take_o)
    else $error("Final parameter taken while the previous result is still held.");

endmodule

// ===== rtl/core/sgr_color_parameter_parser_core.sv =====
// Parses the numeric parameters of terminal SGR sequences, one per transaction,
// and reports the resulting foreground and background colors on the final
// parameter. A parameter can be taken every cycle; it is decoded straight out of
// the input register, so a result is loaded into the output register when its final
// parameter leaves the input register. The only stall is a final parameter that finds the
// previous result still held in the output register and not accepted in that
// cycle. The default colors are programmed through the APB port (foreground at
// 0x0, background at 0x4).
// Depends on sgrcp_pkg, the channel interfaces and the sgrcp_* modules.
module sgr_color_parameter_parser_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sgrcp_param_if.sink                 in_i,
  sgrcp_color_if.source               out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sgrcp_pkg::AddrW-1:0] paddr,
  input  logic [sgrcp_pkg::DataW-1:0] pwdata,
  output logic [sgrcp_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import sgrcp_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  take;

  sgrcp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sgrcp_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .item_o (item)
  );

  sgrcp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .cfg_i  (cfg),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for sgr_color_parameter_parser_core: random SGR parameter streams
// with a built-in color predictor, random stalls on both channels and APB default writes.
// Depends on sgrcp_pkg, the channel interfaces in sgrcp_ifs.sv and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import sgrcp_pkg::*;

  typedef struct packed {
    logic [ParamW-1:0] param;
    logic              last;
  } sgr_param_t;

  typedef struct packed {
    logic [ColorW-1:0] fg;
    logic [ColorW-1:0] bg;
  } color_pair_t;

  localparam logic [ColorW-1:0] SysColors [16] = '{
    24'h000000, 24'h0000CD, 24'h00CD00, 24'h00CDCD,
    24'hEE0000, 24'hCD00CD, 24'hCDCD00, 24'hE5E5E5,
    24'h7F7F7F, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF5C5C, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  localparam logic [7:0] GreySteps [24] = '{
    8'h00, 8'h0B, 8'h16, 8'h21, 8'h2C, 8'h37, 8'h42, 8'h4D,
    8'h58, 8'h63, 8'h6F, 8'h7A, 8'h85, 8'h90, 8'h9B, 8'hA6,
    8'hB1, 8'hBC, 8'hC7, 8'hD3, 8'hDE, 8'hE9, 8'hF4, 8'hFF
  };

  localparam logic [AddrW-1:0] FgDefaultAddr = {RegFgDefault, 2'b00};
  localparam logic [AddrW-1:0] BgDefaultAddr = {RegBgDefault, 2'b00};
  localparam int PhaseItems = 305;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  sgrcp_param_if param_ch ();
  sgrcp_color_if color_ch ();

  sgr_color_parameter_parser_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (param_ch),
    .out_o   (color_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sgr_param_t  param_q [$];
  color_pair_t due_colors [$];
  logic [ParamW-1:0] seq_buf [$];
  sgr_param_t  drive_item;
  color_pair_t want;
  int          items_queued = 0;
  int          fault_count = 0;
  logic        steady = 1'b0;
  logic        param_taken;

  // Predictor state.
  logic [ColorW-1:0] fg_dflt;
  logic [ColorW-1:0] bg_dflt;
  logic [ColorW-1:0] fg_work;
  logic [ColorW-1:0] bg_work;
  phase_e            seq_phase;
  logic              ext_to_bg;
  logic [7:0]        red_acc;
  logic [7:0]        green_acc;

  function automatic logic [ColorW-1:0] pal_color(logic [7:0] idx);
    logic [7:0] n;
    logic [7:0] lv;
    if (idx < 8'd16) return SysColors[idx[3:0]];
    if (idx >= 8'd232) begin
      lv = GreySteps[idx - 8'd232];
      return {lv, lv, lv};
    end
    n = idx - 8'd16;
    return {8'((n % 6) * 51), 8'(((n / 6) % 6) * 51), 8'((n / 36) * 51)};
  endfunction

  function automatic logic [7:0] clip_sub(logic signed [ParamW-1:0] v);
    return (v >= 0 && v <= 255) ? v[7:0] : 8'd0;
  endfunction

  function automatic void put_ext(logic [ColorW-1:0] c);
    if (ext_to_bg) bg_work = c;
    else fg_work = c;
  endfunction

  function automatic void clear_sequence();
    fg_work   = fg_dflt;
    bg_work   = bg_dflt;
    seq_phase = PH_CODE;
    ext_to_bg = 1'b0;
    red_acc   = 8'd0;
    green_acc = 8'd0;
  endfunction

  function automatic void load_default(logic reg_sel, logic [ColorW-1:0] v);
    if (reg_sel == RegFgDefault) begin
      fg_dflt = v;
      fg_work = v;
    end else begin
      bg_dflt = v;
      bg_work = v;
    end
  endfunction

  function automatic void plain_code(logic signed [ParamW-1:0] m);
    if (m >= CodeFgLo && m <= CodeFgHi) fg_work = pal_color(8'(m - CodeFgLo));
    else if (m >= CodeFgBrLo && m <= CodeFgBrHi)
      fg_work = pal_color(8'(m - CodeFgBrLo) + BrightBase);
    else if (m >= CodeBgLo && m <= CodeBgHi) bg_work = pal_color(8'(m - CodeBgLo));
    else if (m >= CodeBgBrLo && m <= CodeBgBrHi)
      bg_work = pal_color(8'(m - CodeBgBrLo) + BrightBase);
    else if (m == CodeFgDef) fg_work = fg_dflt;
    else if (m == CodeBgDef) bg_work = bg_dflt;
    else if (m == CodeFgExt || m == CodeBgExt) begin
      ext_to_bg = (m == CodeBgExt);
      seq_phase = PH_MODE;
    end
  endfunction

  function automatic void absorb_param(logic signed [ParamW-1:0] m, logic fin);
    color_pair_t res;
    case (seq_phase)
      PH_MODE: begin
        if (m == ModeIndex) seq_phase = PH_INDEX;
        else if (m == ModeRgb) seq_phase = PH_RED;
        else seq_phase = PH_CODE;
      end
      PH_INDEX: begin
        put_ext(pal_color(clip_sub(m)));
        seq_phase = PH_CODE;
      end
      PH_RED: begin
        red_acc   = clip_sub(m);
        seq_phase = PH_GREEN;
      end
      PH_GREEN: begin
        green_acc = clip_sub(m);
        seq_phase = PH_BLUE;
      end
      PH_BLUE: begin
        put_ext({clip_sub(m), green_acc, red_acc});
        seq_phase = PH_CODE;
      end
      default: begin
        seq_phase = PH_CODE;
        plain_code(m);
      end
    endcase
    if (fin) begin
      case (seq_phase)
        PH_INDEX: put_ext(pal_color(8'd0));
        PH_RED:   put_ext('0);
        PH_GREEN: put_ext({16'd0, red_acc});
        PH_BLUE:  put_ext({8'd0, green_acc, red_acc});
        default: ;
      endcase
      res.fg = fg_work;
      res.bg = bg_work;
      due_colors.push_back(res);
      clear_sequence();
    end
  endfunction

  function automatic logic take_break();
    return !steady && ($urandom_range(99) < 34);
  endfunction

  task automatic note_fault(string what, logic [ColorW-1:0] exp_v, logic [ColorW-1:0] got_v);
    if (fault_count < 10)
      $display("%0t: %s mismatch, expected %06h, got %06h", $realtime, what, exp_v, got_v);
    fault_count++;
  endtask

  // Parameter driver.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      param_ch.valid <= 1'b0;
    end else if (!param_ch.valid || param_taken) begin
      if (param_q.size() > 0 && !take_break()) begin
        drive_item = param_q.pop_front();
        param_ch.valid <= 1'b1;
        param_ch.param <= drive_item.param;
        param_ch.last  <= drive_item.last;
      end else begin
        param_ch.valid <= 1'b0;
        param_ch.param <= 16'($urandom);
        param_ch.last  <= 1'($urandom);
      end
    end
  end

  always @(negedge clk_i) begin
    color_ch.ready <= rst_ni && !take_break();
  end

  // Input transaction monitor feeding the predictor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      param_taken <= 1'b0;
    end else begin
      param_taken <= param_ch.valid && param_ch.ready;
      if (param_ch.valid && param_ch.ready) absorb_param(param_ch.param, param_ch.last);
    end
  end

  // Result transaction monitor.
  always @(posedge clk_i) begin
    if (rst_ni && color_ch.valid && color_ch.ready) begin
      if (due_colors.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: unexpected result fg %06h bg %06h", $realtime,
                   color_ch.fg_color, color_ch.bg_color);
        fault_count++;
      end else begin
        want = due_colors.pop_front();
        if (color_ch.fg_color !== want.fg) note_fault("fg_color", want.fg, color_ch.fg_color);
        if (color_ch.bg_color !== want.bg) note_fault("bg_color", want.bg, color_ch.bg_color);
      end
    end
  end

  task automatic push_param(logic [ParamW-1:0] v, logic fin);
    sgr_param_t it;
    it.param = v;
    it.last  = fin;
    param_q.push_back(it);
    items_queued++;
  endtask

  function automatic logic [ParamW-1:0] pick_sub();
    case ($urandom_range(19))
      0: return 16'd256;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: return 16'd255;
      default: return 16'($urandom_range(255));
    endcase
  endfunction

  task automatic append_element();
    logic [ParamW-1:0] ext;
    ext = $urandom_range(1) ? CodeBgExt : CodeFgExt;
    case ($urandom_range(9))
      0, 1: seq_buf.push_back($urandom_range(1) ? 16'(CodeFgLo + $urandom_range(7))
                                                : 16'(CodeFgBrLo + $urandom_range(7)));
      2, 3: seq_buf.push_back($urandom_range(1) ? 16'(CodeBgLo + $urandom_range(7))
                                                : 16'(CodeBgBrLo + $urandom_range(7)));
      4: seq_buf.push_back($urandom_range(1) ? CodeFgDef : CodeBgDef);
      5, 6: begin
        seq_buf.push_back(ext);
        seq_buf.push_back(ModeIndex);
        seq_buf.push_back(pick_sub());
      end
      7, 8: begin
        seq_buf.push_back(ext);
        seq_buf.push_back(ModeRgb);
        repeat (3) seq_buf.push_back(pick_sub());
      end
      default: begin
        case ($urandom_range(2))
          0: seq_buf.push_back(16'($urandom_range(127)));
          1: seq_buf.push_back(16'($urandom));
          default: begin
            seq_buf.push_back(ext);
            seq_buf.push_back(16'($urandom_range(15)));
          end
        endcase
      end
    endcase
  endtask

  // Mostly well-formed sequences, some cut short and some pure noise.
  task automatic fill_random(int count);
    int target;
    int n;
    int cut;
    target = items_queued + count;
    while (items_queued < target) begin
      seq_buf.delete();
      if ($urandom_range(99) < 10) begin
        n = $urandom_range(5, 1);
        repeat (n) seq_buf.push_back(16'($urandom));
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) append_element();
        if ($urandom_range(99) < 12) begin
          cut = $urandom_range(seq_buf.size(), 1);
          while (seq_buf.size() > cut) void'(seq_buf.pop_back());
        end
      end
      foreach (seq_buf[k]) push_param(seq_buf[k], k == seq_buf.size() - 1);
    end
  endtask

  task automatic wait_idle();
    while (param_q.size() != 0 || param_ch.valid || due_colors.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_default(logic reg_sel, logic [ColorW-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (reg_sel == RegFgDefault) ? FgDefaultAddr : BgDefaultAddr;
    pwdata  <= {8'($urandom), v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    load_default(reg_sel, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Leaves an unfinished extended color so the next default write hits a live sequence.
  task automatic leave_dangling();
    push_param(16'(CodeFgLo + 3), 1'b0);
    push_param(CodeBgExt, 1'b0);
    push_param(ModeRgb, 1'b0);
    push_param(16'd77, 1'b0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    param_ch.valid = 1'b0;
    param_ch.param = '0;
    param_ch.last  = 1'b0;
    color_ch.ready = 1'b0;
    fg_dflt        = FgDefaultReset;
    bg_dflt        = BgDefaultReset;
    clear_sequence();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_param(CodeFgLo, 1'b0);
    push_param(CodeFgBrHi, 1'b0);
    push_param(CodeBgLo, 1'b0);
    push_param(CodeBgBrHi, 1'b1);
    push_param(CodeFgHi, 1'b0);
    push_param(CodeFgBrLo, 1'b0);
    push_param(CodeBgHi, 1'b0);
    push_param(CodeBgBrLo, 1'b0);
    push_param(CodeFgDef, 1'b0);
    push_param(CodeBgDef, 1'b1);
    push_param(CodeFgExt, 1'b0);
    push_param(ModeIndex, 1'b0);
    push_param(16'd300, 1'b0);
    push_param(CodeBgExt, 1'b0);
    push_param(ModeRgb, 1'b0);
    push_param(16'hFFFF, 1'b0);
    push_param(16'd128, 1'b0);
    push_param(16'h7FFF, 1'b1);
    push_param(CodeBgExt, 1'b1);
    push_param(CodeFgExt, 1'b0);
    push_param(16'h8000, 1'b0);
    push_param(16'(CodeFgLo + 1), 1'b1);
    push_param(CodeFgExt, 1'b0);
    push_param(ModeRgb, 1'b0);
    push_param(16'd10, 1'b1);
    fill_random(PhaseItems);
    leave_dangling();
    wait_idle();

    write_default(RegFgDefault, 24'h000000);
    write_default(RegBgDefault, 24'hFFFFFF);
    fill_random(PhaseItems);
    wait_idle();

    write_default(RegFgDefault, 24'hFFFFFF);
    write_default(RegBgDefault, 24'h000000);
    steady = 1'b1;
    fill_random(PhaseItems);
    leave_dangling();
    wait_idle();
    steady = 1'b0;

    write_default(RegFgDefault, 24'($urandom));
    write_default(RegBgDefault, 24'($urandom));
    fill_random(PhaseItems);
    leave_dangling();
    wait_idle();

    write_default(RegBgDefault, 24'($urandom));
    fill_random(PhaseItems);
    wait_idle();

    write_default(RegFgDefault, 24'($urandom));
    write_default(RegBgDefault, 24'($urandom));
    fill_random(PhaseItems);
    wait_idle();
    repeat (10) @(posedge clk_i);

    fault_count += due_colors.size();
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
